// ----- rtl/core/vcfd_pkg.sv -----
// vcfd_pkg: shared types, codes and the crc-8 (poly 0xd5) helper for the
// control frame deframer; used by the controller, datapath and top level
package vcfd_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] CRC_POLY    = 8'hD5;
  localparam logic [7:0] CRC_MSB     = 8'h80;

  localparam logic [2:0] PH_SYNC    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_COMMAND = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;
  localparam logic [2:0] PH_CRC     = 3'd5;

  localparam logic [1:0] STAT_LISTEN  = 2'd0;
  localparam logic [1:0] STAT_ERROR   = 2'd1;
  localparam logic [1:0] STAT_FRAME   = 2'd2;
  localparam logic [1:0] STAT_PAYLOAD = 2'd3;

  typedef struct packed {
    logic take_byte;
    logic parse;
    logic emit_data;
    logic clr_idx;
    logic inc_idx;
  } vcfd_cmd_t;

  typedef struct packed {
    logic good_frame;
    logic empty_payload;
    logic last_data;
    logic out_free;
  } vcfd_stat_t;

  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_MSB) != 8'd0) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/vcfd_ram.sv -----
// vcfd_ram: generic single write port, single read port ram with
// registered read data; no dependencies
module vcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/vcfd_ctrl.sv -----
// vcfd_ctrl: sequencing state machine of the deframer; issues commands to
// the datapath from its status; depends on vcfd_pkg
module vcfd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  output logic                rx_stall_o,
  input  vcfd_pkg::vcfd_stat_t stat_i,
  output vcfd_pkg::vcfd_cmd_t  cmd_o
);
  import vcfd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PROC = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_DATA = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (rx_valid_i) begin
          cmd_o.take_byte = 1'b1;
          state_d = ST_PROC;
        end
      end
      ST_PROC: begin
        if (stat_i.out_free) begin
          cmd_o.parse = 1'b1;
          if (stat_i.good_frame && !stat_i.empty_payload) begin
            cmd_o.clr_idx = 1'b1;
            state_d = ST_ADDR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ADDR: begin
        state_d = ST_DATA;
      end
      ST_DATA: begin
        if (stat_i.out_free) begin
          cmd_o.emit_data = 1'b1;
          if (stat_i.last_data) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.inc_idx = 1'b1;
            state_d = ST_ADDR;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rx_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/vcfd_dp.sv -----
// vcfd_dp: parse registers, crc, payload store and result register of the
// deframer; depends on vcfd_pkg and vcfd_ram
module vcfd_dp #(
  parameter int MAX_FRAME = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           rx_byte_i,
  input  logic                 res_stall_i,
  output logic                 res_valid_o,
  output logic [1:0]           status_o,
  output logic [6:0]           command_o,
  output logic [5:0]           payload_len_o,
  output logic [7:0]           data_byte_o,
  output logic [5:0]           byte_index_o,
  output logic                 last_o,
  input  vcfd_pkg::vcfd_cmd_t  cmd_i,
  output vcfd_pkg::vcfd_stat_t stat_o
);
  import vcfd_pkg::*;

  localparam int AW = $clog2(MAX_FRAME);
  localparam logic [8:0] MaxLen = 9'(MAX_FRAME - 5);
  localparam logic [AW-1:0] DataBase = AW'(4);

  logic [7:0]    byte_q;
  logic [2:0]    phase_q, phase_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] fend_q, fend_d;
  logic [7:0]    crc_q, crc_d;
  logic [7:0]    cmdb_q, cmdb_d;
  logic [AW-1:0] idx_q;

  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [6:0]    out_cmd_q;
  logic [5:0]    out_len_q;
  logic [7:0]    out_data_q;
  logic [5:0]    out_idx_q;
  logic          out_last_q;

  logic [AW-1:0] len_w;
  logic [31:0]   len_ext;
  logic [31:0]   idx_ext;
  logic [7:0]    crc_step;
  logic          err;
  logic          good;
  logic [7:0]    rdata;
  logic          ram_we;
  logic [AW:0]   pos_inc;

  assign len_w   = (fend_q >= DataBase) ? (fend_q - DataBase) : '0;
  assign len_ext = 32'(len_w);
  assign idx_ext = 32'(idx_q);
  assign crc_step = crc8_d5(crc_q, byte_q);
  assign good    = (phase_q == PH_CRC) && (crc_q == byte_q);
  assign pos_inc = {1'b0, pos_q} + {{AW{1'b0}}, 1'b1};

  assign stat_o.good_frame    = good;
  assign stat_o.empty_payload = (len_w == '0);
  assign stat_o.last_data     = ((idx_q + AW'(1)) == len_w);
  assign stat_o.out_free      = !out_valid_q || !res_stall_i;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    fend_d  = fend_q;
    crc_d   = crc_q;
    cmdb_d  = cmdb_q;
    err     = 1'b0;
    unique case (phase_q)
      PH_SYNC: begin
        if (byte_q == SYNC_BYTE) begin
          crc_d   = crc8_d5(8'd0, byte_q);
          pos_d   = AW'(1);
          phase_d = PH_HEADER;
        end else begin
          err = 1'b1;
        end
      end
      PH_HEADER: begin
        if (byte_q == HEADER_BYTE) begin
          crc_d   = crc_step;
          pos_d   = AW'(2);
          phase_d = PH_COMMAND;
        end else begin
          err = 1'b1;
        end
      end
      PH_COMMAND: begin
        cmdb_d  = byte_q;
        crc_d   = crc_step;
        pos_d   = AW'(3);
        phase_d = PH_LENGTH;
      end
      PH_LENGTH: begin
        if ({1'b0, byte_q} > MaxLen) begin
          err = 1'b1;
        end else begin
          fend_d  = AW'({1'b0, byte_q} + 9'd4);
          crc_d   = crc_step;
          pos_d   = DataBase;
          phase_d = (byte_q != 8'd0) ? PH_DATA : PH_CRC;
        end
      end
      PH_DATA: begin
        crc_d   = crc_step;
        phase_d = (pos_inc < {1'b0, fend_q}) ? PH_DATA : PH_CRC;
        pos_d   = pos_inc[AW-1:0];
      end
      PH_CRC: begin
        err = !good;
      end
      default: begin
        err = 1'b1;
      end
    endcase
    // resync after an error or a completed frame
    if (err || good) begin
      phase_d = PH_SYNC;
      pos_d   = '0;
      crc_d   = 8'd0;
    end
  end

  assign ram_we = cmd_i.parse && (phase_q == PH_DATA);

  vcfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (byte_q),
    .raddr_i (idx_q + DataBase),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      byte_q <= rx_byte_i;
    end
    if (cmd_i.parse) begin
      if (good) begin
        out_status_q <= STAT_FRAME;
        out_cmd_q    <= cmdb_q[7:1];
        out_len_q    <= len_ext[5:0];
        out_data_q   <= 8'd0;
        out_idx_q    <= 6'd0;
        out_last_q   <= (len_w == '0);
      end else begin
        out_status_q <= err ? STAT_ERROR : STAT_LISTEN;
        out_cmd_q    <= 7'd0;
        out_len_q    <= 6'd0;
        out_data_q   <= 8'd0;
        out_idx_q    <= 6'd0;
        out_last_q   <= 1'b1;
      end
    end else if (cmd_i.emit_data) begin
      out_status_q <= STAT_PAYLOAD;
      out_cmd_q    <= cmdb_q[7:1];
      out_len_q    <= len_ext[5:0];
      out_data_q   <= rdata;
      out_idx_q    <= idx_ext[5:0];
      out_last_q   <= stat_o.last_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC;
      pos_q       <= '0;
      fend_q      <= '0;
      crc_q       <= 8'd0;
      cmdb_q      <= 8'd0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.parse) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        fend_q  <= fend_d;
        crc_q   <= crc_d;
        cmdb_q  <= cmdb_d;
      end
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.parse || cmd_i.emit_data) begin
        out_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign command_o     = out_cmd_q;
  assign payload_len_o = out_len_q;
  assign data_byte_o   = out_data_q;
  assign byte_index_o  = out_idx_q;
  assign last_o        = out_last_q;

endmodule

// ----- rtl/core/vtx_control_frame_deframer_core.sv -----
// vtx_control_frame_deframer_core: top level of the control frame deframer
// joins vcfd_ctrl and vcfd_dp; depends on vcfd_pkg
//
// usage: received serial bytes come in on the rx channel (rx_valid_i,
// rx_stall_o, rx_byte_i), one word per byte. results leave on the res
// channel (res_valid_o, res_stall_i and the field ports), one word each.
// every byte gives one result (listening or error); a byte that closes a
// frame with a good crc-8 gives a frame-accepted word followed by one word
// per payload byte, last_o marking the final word caused by that byte.
// a byte is taken into a holding register and parsed once the result
// register is free; no further byte is taken until all results of that
// byte are issued. payload readout passes through an address state and a
// data state per byte, because the payload store has a registered read,
// so a frame with payload holds off the next byte until readout ends.
// reset clears the parser to wait for sync and empties the result register;
// the payload store is not cleared. while the receiver stalls, the pending
// result holds and at most one further byte is taken and waits.
module vtx_control_frame_deframer_core #(
  parameter int MAX_FRAME = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [1:0] status_o,
  output logic [6:0] command_o,
  output logic [5:0] payload_len_o,
  output logic [7:0] data_byte_o,
  output logic [5:0] byte_index_o,
  output logic       last_o
);
  import vcfd_pkg::*;

  vcfd_cmd_t  cmd;
  vcfd_stat_t stat;

  vcfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vcfd_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .res_stall_i   (res_stall_i),
    .res_valid_o   (res_valid_o),
    .status_o      (status_o),
    .command_o     (command_o),
    .payload_len_o (payload_len_o),
    .data_byte_o   (data_byte_o),
    .byte_index_o  (byte_index_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule
